### design/fth_pkg.sv
`default_nettype none
package fth_pkg;

	// Port widths fixed by the interface
	localparam int CMD_W   = 2;
	localparam int NODE_W  = 10;
	localparam int COLOR_W = 10;
	localparam int THR_W   = 11;
	localparam int CFG_W   = 11;
	localparam int OUT_W   = 11;

	// Default sizing
	localparam int NODES_DEF  = 1024;
	localparam int COLORS_DEF = 1024;
	localparam int BUCKET_DEF = 32;

	localparam logic [CFG_W-1:0] NODE_COUNT_RST = 11'd1024;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

	typedef enum logic [1:0] {
		ALU_INC,
		ALU_DEC,
		ALU_ADD
	} alu_op_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_VREAD,
		S_VMOD,
		S_TDIV,
		S_TREAD,
		S_TWRF,
		S_TWRB,
		S_QDIV,
		S_QOFF,
		S_QRUN,
		S_QOUT
	} state_t;

endpackage
`default_nettype wire

### design/frequency_threshold_histogram.sv
`default_nettype none
// Add/remove: read and update the visit count, then, if the color moves, the tallies of
// the old and then the new frequency; ignored items never raise busy. A query scans at
// most 2*(BUCKET_SIZE-1) + NODES/BUCKET_SIZE steps, one tally read a cycle through the
// shared adder, then strobes done. One item at a time: busy stays high until the item is
// finished. Reset: async, active low; a clearing pass over max(NODES+1, COLORS) entries
// (1025 by default) zeroes all stores with busy high. The receiver cannot stall.
module frequency_threshold_histogram #(
	parameter int NODES       = fth_pkg::NODES_DEF,
	parameter int COLORS      = fth_pkg::COLORS_DEF,
	parameter int BUCKET_SIZE = fth_pkg::BUCKET_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// command channel
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [fth_pkg::CMD_W-1:0]   cmd,
	input  wire logic [fth_pkg::NODE_W-1:0]  node,
	input  wire logic [fth_pkg::COLOR_W-1:0] color,
	input  wire logic [fth_pkg::THR_W-1:0]   threshold,
	// result strobe
	output logic                             done,
	output logic [fth_pkg::OUT_W-1:0]        color_total,
	// configuration write channel
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [fth_pkg::CFG_W-1:0]   cfg_data
);

	// Frequencies run 0..NODES, tallies count colors 0..COLORS.
	localparam int FW   = $clog2(NODES + 1);
	localparam int TW   = $clog2(COLORS + 1);
	localparam int OW   = fth_pkg::OUT_W;
	localparam int AW0  = (FW > TW) ? FW : TW;
	localparam int AW   = (AW0 > OW) ? AW0 : OW;
	localparam int NIW  = $clog2(NODES);
	localparam int CIW  = $clog2(COLORS);
	localparam int FIW  = FW;
	localparam int NB   = NODES / BUCKET_SIZE + 1;
	localparam int BIW  = (NB > 1) ? $clog2(NB) : 1;
	localparam int OFW  = (BUCKET_SIZE > 1) ? $clog2(BUCKET_SIZE) : 1;
	localparam int CLR_N = (NODES + 1 > COLORS) ? NODES + 1 : COLORS;
	localparam int CLW  = $clog2(CLR_N);
	localparam int THR_WL = fth_pkg::THR_W;
	// scan index must hold any threshold and the overshoot of a block step
	localparam int IW   = $clog2(NODES + BUCKET_SIZE + 2048);
	// block index by reciprocal multiply, exact for every value below 2**FW
	localparam int      DIV_S = FW + $clog2(BUCKET_SIZE);
	localparam longint  DIV_M = ((64'd1 << DIV_S) + BUCKET_SIZE - 1) / BUCKET_SIZE;
	localparam int      MW    = $clog2(DIV_M + 1);
	localparam int      PW    = FW + MW;

	// Stores: visit counts, color frequencies, tally per frequency, tally per block.
	logic [1:0]    vc_mem [NODES];
	logic [FW-1:0] cf_mem [COLORS];
	logic [TW-1:0] ft_mem [NODES + 1];
	logic [TW-1:0] bt_mem [NB];

	fth_pkg::state_t state_q, state_d;

	logic [CLW-1:0]              clr_q;
	logic [fth_pkg::CFG_W-1:0]   node_count_q;
	logic [fth_pkg::CMD_W-1:0]   cmd_q;
	logic [fth_pkg::NODE_W-1:0]  node_q;
	logic [fth_pkg::COLOR_W-1:0] color_q;

	// tally update sequencing
	logic [FW-1:0]  tf_q;       // frequency whose tally changes now
	logic [FW-1:0]  fnew_q;     // frequency taking the second change
	logic           tup_q;      // direction of the current change
	logic           second_q;   // second change still pending

	// query scan
	logic [IW-1:0]  i_q;
	logic [FW-1:0]  limit_q;
	logic [BIW-1:0] blk_q;
	logic [OFW-1:0] off_q;
	logic [OW-1:0]  total_q;
	logic           pend_s1;
	logic           blk_s1;

	// registered read data
	logic [1:0]    vc_rd;
	logic [FW-1:0] cf_rd;
	logic [TW-1:0] ft_rd;
	logic [TW-1:0] bt_rd;

	// write ports
	logic           vc_we, cf_we, ft_we, bt_we;
	logic [1:0]     vc_wd;
	logic [FW-1:0]  cf_wd;
	logic [TW-1:0]  ft_wd, bt_wd;
	logic [NIW-1:0] vc_wa, node_idx;
	logic [CIW-1:0] cf_wa, color_idx;
	logic [FIW-1:0] ft_wa, ft_ra;
	logic [BIW-1:0] bt_wa;

	// shared adder
	logic [AW-1:0]     alu_a, alu_b, alu_y;
	fth_pkg::alu_op_t  alu_op;

	logic           accept;
	logic           clearing;
	logic           in_range;
	logic           is_add;
	logic           vc_ok;
	logic           trig;
	logic [1:0]     vc_new;
	logic           q_issue;
	logic           q_blk;
	logic [FW-1:0]  div_in;
	logic [PW-1:0]  div_prod;
	logic [BIW-1:0] div_q;
	logic [THR_WL-1:0] thr_eff;
	logic [FW-1:0]  limit_eff;

	assign accept    = start && !busy;
	assign clearing  = (state_q == fth_pkg::S_CLEAR);
	assign cfg_ready = 1'b1;
	assign node_idx  = NIW'(node_q);
	assign color_idx = CIW'(color_q);
	assign in_range  = (32'(node) < NODES) && (32'(color) < COLORS);
	assign is_add    = (cmd_q == fth_pkg::CMD_ADD);

	// Threshold zero counts as one; the summed range stops at NODES.
	assign thr_eff   = (threshold == '0) ? THR_WL'(1) : threshold;
	assign limit_eff = (32'(node_count_q) > NODES) ? FW'(NODES) : FW'(node_count_q);

	// Block index of a frequency: multiply by the scaled reciprocal, take the top.
	assign div_in   = (state_q == fth_pkg::S_QDIV) ? FW'(i_q) : tf_q;
	assign div_prod = PW'(div_in) * PW'(DIV_M);
	assign div_q    = BIW'(div_prod >> DIV_S);

	// Visit-count step: saturate at both ends; the color moves only on 1<->2.
	always_comb begin
		if (is_add) begin
			vc_ok  = (vc_rd != 2'd3);
			vc_new = vc_rd + 2'd1;
			trig   = (vc_rd == 2'd1) && (32'(cf_rd) < NODES);
		end else begin
			vc_ok  = (vc_rd != 2'd0);
			vc_new = vc_rd - 2'd1;
			trig   = (vc_rd == 2'd2) && (cf_rd != '0);
		end
	end

	// Scan step: a whole block when aligned and it fits below the limit.
	assign q_issue = (i_q <= IW'(limit_q));
	assign q_blk   = (off_q == '0) && ((i_q + IW'(BUCKET_SIZE - 1)) <= IW'(limit_q));

	// Operand select for the shared adder.
	always_comb begin
		alu_a  = AW'(total_q);
		alu_b  = blk_s1 ? AW'(bt_rd) : AW'(ft_rd);
		alu_op = fth_pkg::ALU_ADD;
		unique case (state_q)
			fth_pkg::S_VMOD: begin
				alu_a  = AW'(cf_rd);
				alu_op = is_add ? fth_pkg::ALU_INC : fth_pkg::ALU_DEC;
			end
			fth_pkg::S_TWRF: begin
				alu_a  = AW'(ft_rd);
				alu_op = tup_q ? fth_pkg::ALU_INC : fth_pkg::ALU_DEC;
			end
			fth_pkg::S_TWRB: begin
				alu_a  = AW'(bt_rd);
				alu_op = tup_q ? fth_pkg::ALU_INC : fth_pkg::ALU_DEC;
			end
			default: begin
			end
		endcase
	end

	fth_alu #(.W(AW)) u_alu (
		.a  (alu_a),
		.b  (alu_b),
		.op (alu_op),
		.y  (alu_y)
	);

	// Next state and strobes.
	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		done    = 1'b0;
		vc_we   = 1'b0;
		cf_we   = 1'b0;
		ft_we   = 1'b0;
		bt_we   = 1'b0;
		unique case (state_q)
			fth_pkg::S_CLEAR: begin
				vc_we = (32'(clr_q) < NODES);
				cf_we = (32'(clr_q) < COLORS);
				ft_we = (32'(clr_q) < NODES + 1);
				bt_we = (32'(clr_q) < NB);
				if (32'(clr_q) == CLR_N - 1) begin
					state_d = fth_pkg::S_IDLE;
				end
			end
			fth_pkg::S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					priority if (cmd == fth_pkg::CMD_QUERY) begin
						state_d = fth_pkg::S_QDIV;
					end else if ((cmd == fth_pkg::CMD_ADD || cmd == fth_pkg::CMD_REMOVE)
						&& in_range) begin
						state_d = fth_pkg::S_VREAD;
					end else begin
						state_d = fth_pkg::S_IDLE;
					end
				end
			end
			fth_pkg::S_VREAD: state_d = fth_pkg::S_VMOD;
			fth_pkg::S_VMOD: begin
				vc_we = vc_ok;
				cf_we = vc_ok && trig;
				state_d = (vc_ok && trig) ? fth_pkg::S_TDIV : fth_pkg::S_IDLE;
			end
			fth_pkg::S_TDIV: begin
				if (tf_q != '0) begin
					state_d = fth_pkg::S_TREAD;
				end else if (!second_q) begin
					state_d = fth_pkg::S_IDLE;
				end
			end
			fth_pkg::S_TREAD: state_d = fth_pkg::S_TWRF;
			fth_pkg::S_TWRF: begin
				ft_we   = 1'b1;
				state_d = fth_pkg::S_TWRB;
			end
			fth_pkg::S_TWRB: begin
				bt_we   = 1'b1;
				state_d = second_q ? fth_pkg::S_TDIV : fth_pkg::S_IDLE;
			end
			fth_pkg::S_QDIV: begin
				state_d = (i_q > IW'(limit_q)) ? fth_pkg::S_QOUT : fth_pkg::S_QOFF;
			end
			fth_pkg::S_QOFF: state_d = fth_pkg::S_QRUN;
			fth_pkg::S_QRUN: begin
				if (!q_issue) begin
					state_d = fth_pkg::S_QOUT;
				end
			end
			fth_pkg::S_QOUT: begin
				done    = 1'b1;
				state_d = fth_pkg::S_IDLE;
			end
			default: state_d = fth_pkg::S_IDLE;
		endcase
	end

	// Write data and addresses: zeros during the clearing pass.
	assign vc_wd = clearing ? 2'd0 : vc_new;
	assign cf_wd = clearing ? '0 : FW'(alu_y);
	assign ft_wd = clearing ? '0 : TW'(alu_y);
	assign bt_wd = clearing ? '0 : TW'(alu_y);
	assign vc_wa = clearing ? NIW'(clr_q) : node_idx;
	assign cf_wa = clearing ? CIW'(clr_q) : color_idx;
	assign ft_wa = clearing ? FIW'(clr_q) : tf_q;
	assign bt_wa = clearing ? BIW'(clr_q) : blk_q;
	assign ft_ra = (state_q == fth_pkg::S_QRUN) ? FIW'(i_q) : tf_q;

	assign color_total = total_q;

	// Memories: one write and one registered read each per cycle.
	always_ff @(posedge clk) begin
		if (vc_we) begin
			vc_mem[vc_wa] <= vc_wd;
		end
		vc_rd <= vc_mem[node_idx];
	end

	always_ff @(posedge clk) begin
		if (cf_we) begin
			cf_mem[cf_wa] <= cf_wd;
		end
		cf_rd <= cf_mem[color_idx];
	end

	always_ff @(posedge clk) begin
		if (ft_we) begin
			ft_mem[ft_wa] <= ft_wd;
		end
		ft_rd <= ft_mem[ft_ra];
	end

	always_ff @(posedge clk) begin
		if (bt_we) begin
			bt_mem[bt_wa] <= bt_wd;
		end
		bt_rd <= bt_mem[blk_q];
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fth_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: clear sweep, config, scan pipeline flag, second-change flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			node_count_q <= fth_pkg::NODE_COUNT_RST;
			pend_s1      <= 1'b0;
			second_q     <= 1'b0;
		end else begin
			if (clearing) begin
				clr_q <= clr_q + CLW'(1);
			end
			if (cfg_valid && cfg_ready) begin
				node_count_q <= cfg_data;
			end
			pend_s1 <= (state_q == fth_pkg::S_QRUN) && q_issue;
			if (state_q == fth_pkg::S_VMOD) begin
				second_q <= 1'b1;
			end else if ((state_q == fth_pkg::S_TDIV && tf_q == '0)
				|| state_q == fth_pkg::S_TWRB) begin
				second_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		blk_s1 <= q_blk;
		// fold the registered tally read of the last scan step into the running total
		if (pend_s1) begin
			total_q <= OW'(alu_y);
		end
		unique case (state_q)
			fth_pkg::S_IDLE: begin
				if (accept) begin
					cmd_q   <= cmd;
					node_q  <= node;
					color_q <= color;
					i_q     <= IW'(thr_eff);
					limit_q <= limit_eff;
					total_q <= '0;
				end
			end
			fth_pkg::S_VMOD: begin
				// first drop the old frequency, then raise the new one
				tf_q   <= cf_rd;
				fnew_q <= FW'(alu_y);
				tup_q  <= 1'b0;
			end
			fth_pkg::S_TDIV: begin
				if (tf_q != '0) begin
					blk_q <= div_q;
				end else begin
					tf_q  <= fnew_q;
					tup_q <= 1'b1;
				end
			end
			fth_pkg::S_TWRB: begin
				tf_q  <= fnew_q;
				tup_q <= 1'b1;
			end
			fth_pkg::S_QDIV: blk_q <= div_q;
			fth_pkg::S_QOFF: begin
				off_q <= OFW'(i_q - IW'(blk_q) * IW'(BUCKET_SIZE));
			end
			fth_pkg::S_QRUN: begin
				if (q_issue) begin
					if (q_blk) begin
						i_q   <= i_q + IW'(BUCKET_SIZE);
						blk_q <= blk_q + BIW'(1);
					end else begin
						i_q <= i_q + IW'(1);
						// advance the offset, wrap into the next block
						if (off_q == OFW'(BUCKET_SIZE - 1)) begin
							off_q <= '0;
							blk_q <= blk_q + BIW'(1);
						end else begin
							off_q <= off_q + OFW'(1);
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

### design/fth_alu.sv
`default_nettype none
module fth_alu #(
	parameter int W = 11
) (
	input  wire logic [W-1:0]        a,
	input  wire logic [W-1:0]        b,
	input  wire fth_pkg::alu_op_t    op,
	output logic [W-1:0]             y
);

	always_comb begin
		unique case (op)
			fth_pkg::ALU_INC: y = a + W'(1);
			fth_pkg::ALU_DEC: y = a - W'(1);
			fth_pkg::ALU_ADD: y = a + b;
			default:          y = a;
		endcase
	end

endmodule
`default_nettype wire

### design/fth_checker.sv
`default_nettype none
module fth_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      start,
	input wire logic                      busy,
	input wire logic [fth_pkg::CMD_W-1:0] cmd,
	input wire logic                      done
);

	// a result only comes out of a running item
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done while not busy");

	// result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	// block returns to idle right after the result
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("still busy after result");

	// an accepted query keeps the block busy
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && cmd == fth_pkg::CMD_QUERY) |=> (busy && !done))
		else $error("query accepted but block not busy");

endmodule

bind frequency_threshold_histogram fth_checker u_fth_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done)
);
`default_nettype wire

### sim/tb_frequency_threshold_histogram.sv
`timescale 1ns / 100ps

module tb_frequency_threshold_histogram;

	localparam logic [fth_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int NODES  = fth_pkg::NODES_DEF;
	localparam int COLORS = fth_pkg::COLORS_DEF;
	// Nodes in the working window of the random phases
	localparam int POOL   = 80;
	// Idle cycles after the last owed total before a register write
	localparam int SETTLE = 16;
	// Run limit in cycles, set well above what about 430 items and the clearing pass need
	localparam int LIMIT  = 600000;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic [fth_pkg::CMD_W-1:0] cmd;
	logic [fth_pkg::NODE_W-1:0] node;
	logic [fth_pkg::COLOR_W-1:0] color;
	logic [fth_pkg::THR_W-1:0] threshold;
	logic done;
	logic [fth_pkg::OUT_W-1:0] color_total;
	logic cfg_valid;
	logic cfg_ready;
	logic [fth_pkg::CFG_W-1:0] cfg_data;

	// Shadow of the block's stores, updated as each item is accepted
	logic [1:0] visit_cnt [NODES];
	int unsigned color_freq [COLORS];
	int unsigned freq_colors [NODES+1];
	logic [fth_pkg::CFG_W-1:0] node_limit;

	// Totals still owed by the block, oldest first
	logic [fth_pkg::OUT_W-1:0] pending_totals [$];
	logic [fth_pkg::OUT_W-1:0] want_total;

	logic [fth_pkg::COLOR_W-1:0] window_color [POOL];

	int errors;
	int items_sent;
	int totals_checked;
	int cfg_writes;
	int burst_left;
	int cycle_count;

	frequency_threshold_histogram uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.node       (node),
		.color      (color),
		.threshold  (threshold),
		.done       (done),
		.color_total(color_total),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Run limit: a hang anywhere ends the run as a failure
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("timeout after %0d cycles, %0d totals outstanding", cycle_count,
				pending_totals.size());
			$display("tb_frequency_threshold_histogram NOT OK");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int want, input int got);
		errors++;
		$display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
	endtask

	// Move a color's frequency by one step, keeping the per-frequency tally in line.
	// Frequency zero is never tallied.
	function automatic void shift_color(input int unsigned c, input bit up);
		int unsigned f;
		f = color_freq[c];
		if (f != 0)
			freq_colors[f]--;
		f = up ? f + 1 : f - 1;
		if (f != 0)
			freq_colors[f]++;
		color_freq[c] = f;
	endfunction

	function automatic void note_visit(input logic [fth_pkg::NODE_W-1:0] n,
			input logic [fth_pkg::COLOR_W-1:0] c, input bit add);
		if (add) begin
			// Count saturates at three
			if (visit_cnt[n] == 2'd3)
				return;
			visit_cnt[n]++;
			// Second visit lifts the color unless it is already at the top frequency
			if (visit_cnt[n] == 2'd2 && color_freq[c] < NODES)
				shift_color(c, 1'b1);
		end else begin
			if (visit_cnt[n] == 2'd0)
				return;
			visit_cnt[n]--;
			// Drop to one visit lowers the color unless it has nothing left
			if (visit_cnt[n] == 2'd1 && color_freq[c] > 0)
				shift_color(c, 1'b0);
		end
	endfunction

	// Colors whose frequency lies in [threshold, node_count], capped at NODES.
	// Block sums in the block only regroup the same entries, so a plain walk matches.
	function automatic logic [fth_pkg::OUT_W-1:0] colors_at_least(
			input logic [fth_pkg::THR_W-1:0] t);
		int unsigned lo;
		int unsigned hi;
		int unsigned sum;
		lo = (t == 0) ? 1 : t;
		hi = (node_limit > NODES) ? NODES : node_limit;
		sum = 0;
		for (int unsigned f = lo; f <= hi; f++)
			sum += freq_colors[f];
		return sum[fth_pkg::OUT_W-1:0];
	endfunction

	// Hand one item to the block, record what it should do, then pace the sender
	task automatic issue_item(input logic [fth_pkg::CMD_W-1:0] c,
			input logic [fth_pkg::NODE_W-1:0] n, input logic [fth_pkg::COLOR_W-1:0] k,
			input logic [fth_pkg::THR_W-1:0] t);
		start <= 1'b1;
		cmd <= c;
		node <= n;
		color <= k;
		threshold <= t;
		do @(posedge clk); while (busy);
		items_sent++;
		case (c)
			fth_pkg::CMD_ADD:    note_visit(n, k, 1'b1);
			fth_pkg::CMD_REMOVE: note_visit(n, k, 1'b0);
			fth_pkg::CMD_QUERY:  pending_totals = {pending_totals, colors_at_least(t)};
			default:    ;
		endcase
		// Bursts of back-to-back items, sometimes long, separated by random gaps
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
			burst_left = ($urandom_range(3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
		end
	endtask

	// Write node_count only once the block has gone quiet
	task automatic write_node_count(input logic [fth_pkg::CFG_W-1:0] value);
		start <= 1'b0;
		while (pending_totals.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		node_limit = value;
		cfg_writes++;
	endtask

	task automatic query(input logic [fth_pkg::THR_W-1:0] t);
		issue_item(fth_pkg::CMD_QUERY, 10'($urandom), 10'($urandom), t);
	endtask

	// Saturated and empty visit counts, empty color frequency, unused command,
	// and thresholds at zero and at the top
	task automatic test_visit_edges();
		query(11'd1);
		repeat (4) issue_item(fth_pkg::CMD_ADD, 10'd5, 10'd7, 11'd0);
		query(11'd0);
		query(11'd1);
		query(11'd2);
		query(11'd2047);
		issue_item(fth_pkg::CMD_REMOVE, 10'd9, 10'd7, 11'd0);
		repeat (2) issue_item(fth_pkg::CMD_REMOVE, 10'd5, 10'd7, 11'd0);
		repeat (3) issue_item(fth_pkg::CMD_ADD, 10'd6, 10'd9, 11'd0);
		// Second drop reaches one visit on a color that never rose
		repeat (2) issue_item(fth_pkg::CMD_REMOVE, 10'd6, 10'd10, 11'd0);
		query(11'd1);
		issue_item(CMD_UNUSED, 10'd1023, 10'd1023, 11'd2047);
		repeat (2) issue_item(fth_pkg::CMD_ADD, 10'd1023, 10'd1023, 11'd2047);
		repeat (2) issue_item(fth_pkg::CMD_ADD, 10'd0, 10'd0, 11'd0);
		query(11'd1);
	endtask

	// node_count at zero, one and the top of its field
	task automatic test_node_count_limits();
		write_node_count(11'd0);
		query(11'd0);
		query(11'd1);
		write_node_count(11'd1);
		query(11'd1);
		write_node_count(11'd2047);
		query(11'd1024);
		query(11'd1);
	endtask

	// Windowed traffic: nodes keep their color, with some stray items mixed in
	task automatic run_window_phase(input int n_items, input int add_pct, input int rem_pct);
		int r;
		bit stray;
		logic [fth_pkg::NODE_W-1:0] n;
		logic [fth_pkg::COLOR_W-1:0] k;
		logic [fth_pkg::THR_W-1:0] t;
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(99);
			stray = ($urandom_range(99) < 8);
			n = stray ? 10'($urandom) : 10'($urandom_range(POOL - 1));
			k = stray ? 10'($urandom) : window_color[n];
			t = ($urandom_range(3) != 0) ? 11'($urandom_range(1, 50)) : 11'($urandom);
			if (r < add_pct)
				issue_item(fth_pkg::CMD_ADD, n, k, t);
			else if (r < add_pct + rem_pct)
				issue_item(fth_pkg::CMD_REMOVE, n, k, t);
			else if (r < 97)
				issue_item(fth_pkg::CMD_QUERY, n, k, t);
			else
				issue_item(CMD_UNUSED, n, k, t);
		end
	endtask

	task automatic test_random_window();
		logic [fth_pkg::COLOR_W-1:0] tint_a;
		logic [fth_pkg::COLOR_W-1:0] tint_b;
		tint_a = 10'($urandom);
		tint_b = tint_a ^ 10'($urandom_range(1, 1023));
		for (int n = 0; n < POOL; n++)
			window_color[n] = n[0] ? tint_b : tint_a;
		write_node_count(11'd1024);
		run_window_phase(100, 60, 15);
		write_node_count(11'd64);
		run_window_phase(100, 45, 25);
		write_node_count(11'd33);
		run_window_phase(100, 35, 35);
		write_node_count(11'($urandom_range(40, 2047)));
		run_window_phase(100, 50, 20);
	endtask

	// Compare every strobed total against the oldest one owed
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_totals.size() == 0) begin
				report_mismatch("color_total with no query waiting", -1, color_total);
			end else begin
				want_total = pending_totals.pop_front();
				totals_checked++;
				if (color_total !== want_total)
					report_mismatch("color_total", want_total, color_total);
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= fth_pkg::CMD_ADD;
		node <= '0;
		color <= '0;
		threshold <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		errors = 0;
		items_sent = 0;
		totals_checked = 0;
		cfg_writes = 0;
		burst_left = 0;
		cycle_count = 0;
		for (int n = 0; n < NODES; n++)
			visit_cnt[n] = 2'd0;
		for (int c = 0; c < COLORS; c++)
			color_freq[c] = 0;
		for (int f = 0; f <= NODES; f++)
			freq_colors[f] = 0;
		node_limit = fth_pkg::NODE_COUNT_RST;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_visit_edges();
		test_node_count_limits();
		test_random_window();

		// Drain, then give the block time to show any stray strobe
		start <= 1'b0;
		while (pending_totals.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("ran %0d items, checked %0d query totals, wrote node_count %0d times",
			items_sent, totals_checked, cfg_writes);
		$display("covered visit limits, empty color frequency, node_count 0 to 2047");
		if (errors == 0)
			$display("tb_frequency_threshold_histogram OK");
		else
			$display("tb_frequency_threshold_histogram NOT OK");
		$finish;
	end

endmodule
